/* hdl/ppl_pkg.sv */
// Package for the positional point list: codes, widths and the command word
// that the list cells share. No dependencies.

package ppl_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_BITS  = $clog2(CAPACITY);
  localparam int unsigned POS_BITS  = 5;
  localparam int unsigned CNT_BITS  = 5;
  localparam int unsigned TDATA_BITS = 72;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] x;
    logic [WORD_BITS-1:0] y;
  } point_t;

  // Broadcast to every cell: a committed insert or remove and where it lands.
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [POS_BITS-1:0] pos;
    point_t              pt;
  } cmd_t;

endpackage

/* hdl/positional_point_list_core.sv */
// Top level of the positional point list: command decode, the row of cells,
// read selection and the result register. Depends on ppl_pkg and ppl_cell.

// Usage:
// The slave stream carries one command word per handshake: tuser is the
// operation (insert, remove, read), tdata the position and the x and y words.
// The master stream returns one result word per command: tuser is the status
// (ok, invalid position, empty, full), tdata the length after the command and
// the point for a successful read (zero otherwise).
// The result shows in the cycle after acceptance. Without stalls, throughput
// is one command per cycle: every cell shifts or holds in parallel, and the
// length register updates in the same cycle. The result register frees as it
// is taken, so s_axis_tready follows m_axis_tready whenever a result waits.
// When the receiver stalls, the result holds and no new command is taken.
// Reset empties the list and drops any pending result; stored points are left
// as they are and only entries below the length are ever read.

module positional_point_list_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low bit up: position[4:0], x_word[36:5], y_word[68:37], zero fill.
  input  logic [ppl_pkg::TDATA_BITS-1:0] s_axis_tdata,
  // tuser: operation[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low bit up: count[4:0], x_read[36:5], y_read[68:37], zero fill.
  output logic [ppl_pkg::TDATA_BITS-1:0] m_axis_tdata,
  // tuser: status[1:0].
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned CAP = ppl_pkg::CAPACITY;
  localparam int unsigned WB  = ppl_pkg::WORD_BITS;

  logic                          accept;
  logic [ppl_pkg::POS_BITS-1:0]  pos;
  ppl_pkg::point_t               in_pt;
  ppl_pkg::cmd_t                 cmd;
  ppl_pkg::point_t               ent [CAP];
  ppl_pkg::point_t               rd_pt;
  ppl_pkg::status_e              status;

  logic [ppl_pkg::CNT_BITS-1:0]  count_q, count_d;
  logic                          out_valid_q;
  ppl_pkg::status_e              out_status_q;
  logic [ppl_pkg::CNT_BITS-1:0]  out_count_q;
  ppl_pkg::point_t               out_pt_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos     = s_axis_tdata[ppl_pkg::POS_BITS-1:0];
  assign in_pt.x = s_axis_tdata[ppl_pkg::POS_BITS +: WB];
  assign in_pt.y = s_axis_tdata[ppl_pkg::POS_BITS + WB +: WB];

  assign rd_pt = ent[pos[ppl_pkg::IDX_BITS-1:0]];

  always_comb begin
    status  = ppl_pkg::ST_BAD_POS;
    count_d = count_q;
    cmd.ins = 1'b0;
    cmd.rem = 1'b0;
    cmd.pos = pos;
    cmd.pt  = in_pt;
    case (s_axis_tuser)
      ppl_pkg::OP_INSERT: begin
        if (count_q == ppl_pkg::CNT_BITS'(CAP)) begin
          status = ppl_pkg::ST_FULL;
        end else if (pos <= count_q) begin
          status  = ppl_pkg::ST_OK;
          cmd.ins = accept;
          count_d = count_q + 1'b1;
        end
      end
      ppl_pkg::OP_REMOVE, ppl_pkg::OP_READ: begin
        if (count_q == '0) begin
          status = ppl_pkg::ST_EMPTY;
        end else if (pos < count_q) begin
          status = ppl_pkg::ST_OK;
          if (s_axis_tuser == ppl_pkg::OP_REMOVE) begin
            cmd.rem = accept;
            count_d = count_q - 1'b1;
          end
        end
      end
      default: status = ppl_pkg::ST_BAD_POS;
    endcase
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    ppl_pkg::point_t left, right;
    if (i == 0) begin : g_head
      assign left = in_pt;
    end else begin : g_left
      assign left = ent[i-1];
    end
    if (i == CAP - 1) begin : g_tail
      assign right = ent[i];
    end else begin : g_right
      assign right = ent[i+1];
    end
    ppl_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .cell_idx_i (ppl_pkg::IDX_BITS'(i)),
      .left_i     (left),
      .right_i    (right),
      .ent_o      (ent[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status;
      out_count_q  <= count_d;
      if (s_axis_tuser == ppl_pkg::OP_READ && status == ppl_pkg::ST_OK) begin
        out_pt_q <= rd_pt;
      end else begin
        out_pt_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {
    (ppl_pkg::TDATA_BITS - ppl_pkg::CNT_BITS - 2 * WB)'(0),
    out_pt_q.y, out_pt_q.x, out_count_q
  };

endmodule

/* hdl/ppl_cell.sv */
// One list cell: holds a single point and shifts it to or from its neighbors.
// Depends on ppl_pkg.

module ppl_cell (
  input  logic                         clk_i,
  input  ppl_pkg::cmd_t                cmd_i,
  input  logic [ppl_pkg::IDX_BITS-1:0] cell_idx_i,
  input  ppl_pkg::point_t              left_i,
  input  ppl_pkg::point_t              right_i,
  output ppl_pkg::point_t              ent_o
);

  ppl_pkg::point_t ent_q, ent_d;
  logic [ppl_pkg::POS_BITS-1:0] idx;

  assign idx = ppl_pkg::POS_BITS'(cell_idx_i);

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.ins) begin
      if (idx == cmd_i.pos) begin
        ent_d = cmd_i.pt;
      end else if (idx > cmd_i.pos) begin
        ent_d = left_i;
      end
    end else if (cmd_i.rem && (idx >= cmd_i.pos)) begin
      // Entries past the length may take junk from the right; they are never read.
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

/* hdl/ppl_checker.sv */
// Port-level checker for positional_point_list_core, attached by bind.
// Depends on ppl_pkg.

module ppl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [ppl_pkg::TDATA_BITS-1:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  localparam int unsigned CB = ppl_pkg::CNT_BITS;
  localparam int unsigned WB = ppl_pkg::WORD_BITS;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CB-1:0] <= CB'(ppl_pkg::CAPACITY))
    else $error("length above capacity");

  a_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ppl_pkg::ST_OK |-> m_axis_tdata[CB +: 2*WB] == '0)
    else $error("point not zero on a failed command");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ppl_pkg::ST_FULL
      |-> m_axis_tdata[CB-1:0] == CB'(ppl_pkg::CAPACITY))
    else $error("full status with a list that is not full");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ppl_pkg::ST_EMPTY |-> m_axis_tdata[CB-1:0] == '0)
    else $error("empty status with a list that is not empty");

endmodule

bind positional_point_list_core ppl_checker u_ppl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/positional_point_list_core_tb.sv */
// Testbench for positional_point_list_core: a table of directed commands, then random
// insert/remove/read traffic checked against a local model of the list.
// Depends on ppl_pkg and the RTL of the block only.

module positional_point_list_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ppl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1900;

  typedef struct {
    status_e              status;
    logic [CNT_BITS-1:0]  count;
    logic [WORD_BITS-1:0] x_rd;
    logic [WORD_BITS-1:0] y_rd;
  } list_result_t;

  typedef struct {
    logic [1:0]           op;
    logic [POS_BITS-1:0]  pos;
    logic [WORD_BITS-1:0] x_wr;
    logic [WORD_BITS-1:0] y_wr;
    int unsigned          reps;     // above one: random points, each appended at the tail
    bit                   typed;
    list_result_t         res;
  } cmd_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_BITS-1:0] s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_ready = 1'b0;
  logic [TDATA_BITS-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  // Local copy of the list contents.
  logic [WORD_BITS-1:0] list_x [CAPACITY];
  logic [WORD_BITS-1:0] list_y [CAPACITY];
  int unsigned          list_len = 0;

  list_result_t pending_results [$];
  cmd_row_t     cmd_table [$];
  int unsigned  fail_count = 0;
  bit           steady = 1'b0;

  always #10 clk_i = ~clk_i;

  positional_point_list_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Applies one command to the local list and returns the answer it should give.
  function automatic list_result_t list_apply(input logic [1:0] op, input logic [4:0] pos,
                                              input logic [31:0] xw, input logic [31:0] yw);
    list_result_t r;
    r.status = ST_BAD_POS;
    r.x_rd   = '0;
    r.y_rd   = '0;
    if (op == OP_INSERT) begin
      if (list_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (pos <= list_len) begin
        for (int i = list_len; i > pos; i--) begin
          list_x[i] = list_x[i-1];
          list_y[i] = list_y[i-1];
        end
        list_x[pos] = xw;
        list_y[pos] = yw;
        list_len++;
        r.status = ST_OK;
      end
    end else if (op == OP_REMOVE || op == OP_READ) begin
      if (list_len == 0) begin
        r.status = ST_EMPTY;
      end else if (pos < list_len) begin
        r.status = ST_OK;
        if (op == OP_READ) begin
          r.x_rd = list_x[pos];
          r.y_rd = list_y[pos];
        end else begin
          for (int i = pos; i + 1 < list_len; i++) begin
            list_x[i] = list_x[i+1];
            list_y[i] = list_y[i+1];
          end
          list_len--;
        end
      end
    end
    r.count = list_len[CNT_BITS-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] op, input int pos, input logic [31:0] xw,
                                  input logic [31:0] yw, input int unsigned reps,
                                  input bit typed, input status_e st, input int cnt,
                                  input logic [31:0] xr, input logic [31:0] yr);
    cmd_row_t row;
    row.op = op;
    row.pos = pos[POS_BITS-1:0];
    row.x_wr = xw;
    row.y_wr = yw;
    row.reps = reps;
    row.typed = typed;
    row.res.status = st;
    row.res.count = cnt[CNT_BITS-1:0];
    row.res.x_rd = xr;
    row.res.y_rd = yr;
    cmd_table.push_back(row);
  endfunction

  // Offers one command word; returns at the edge where it was taken.
  task automatic offer_word(input logic [1:0] op, input logic [4:0] pos, input logic [31:0] xw,
                            input logic [31:0] yw, input bit typed, input list_result_t want,
                            input bit drain);
    int unsigned gap;
    list_result_t res;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (drain || gap != 0) begin
      s_valid <= 1'b0;
    end
    if (drain) begin
      do @(posedge clk_i); while (pending_results.size() != 0);
    end
    repeat (gap) @(posedge clk_i);
    s_valid <= 1'b1;
    s_tdata <= {3'b000, yw, xw, pos};
    s_tuser <= op;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    res = list_apply(op, pos, xw, yw);
    pending_results.push_back(typed ? want : res);
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result side: random stalls, one long hold-off, and the comparison.
  initial begin
    int unsigned stall;
    int unsigned taken;
    list_result_t want;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (taken == 400) begin
        stall = 150;
      end
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) @(negedge clk_i);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h/%h", $time,
                 m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
        check_field("count", 32'(want.count), 32'(m_axis_tdata[4:0]));
        check_field("x_read", want.x_rd, m_axis_tdata[36:5]);
        check_field("y_read", want.y_rd, m_axis_tdata[68:37]);
      end
      taken++;
      @(posedge clk_i);
    end
  end

  // Command side: reset, directed table, random traffic, end of run.
  initial begin
    cmd_row_t     row;
    list_result_t none;
    logic [1:0]   op;
    logic [4:0]   pos;
    logic [31:0]  xw;
    logic [31:0]  yw;
    bit           filling;
    int unsigned  r;

    none.status = ST_OK;
    none.count  = '0;
    none.x_rd   = '0;
    none.y_rd   = '0;

    add_row(OP_READ,   0,  '0, '0, 1, 1, ST_EMPTY,   0, '0, '0);
    add_row(OP_REMOVE, 0,  '0, '0, 1, 1, ST_EMPTY,   0, '0, '0);
    add_row(OP_UNUSED, 0,  '0, '0, 1, 1, ST_BAD_POS, 0, '0, '0);
    add_row(OP_INSERT, 1,  '1, '1, 1, 1, ST_BAD_POS, 0, '0, '0);
    add_row(OP_INSERT, 0,  '1, '0, 1, 1, ST_OK,      1, '0, '0);
    add_row(OP_INSERT, 0,  '0, '1, 1, 1, ST_OK,      2, '0, '0);
    add_row(OP_READ,   1,  '0, '0, 1, 1, ST_OK,      2, '1, '0);
    add_row(OP_READ,   2,  '0, '0, 1, 1, ST_BAD_POS, 2, '0, '0);
    add_row(OP_REMOVE, 2,  '0, '0, 1, 1, ST_BAD_POS, 2, '0, '0);
    add_row(OP_REMOVE, 31, '0, '0, 1, 1, ST_BAD_POS, 2, '0, '0);
    add_row(OP_INSERT, 31, '1, '1, 1, 1, ST_BAD_POS, 2, '0, '0);
    add_row(OP_UNUSED, 31, '1, '1, 1, 1, ST_BAD_POS, 2, '0, '0);
    add_row(OP_REMOVE, 0,  '0, '0, 1, 1, ST_OK,      1, '0, '0);
    add_row(OP_READ,   0,  '1, '1, 1, 1, ST_OK,      1, '1, '0);
    add_row(OP_INSERT, 0,  '0, '0, 15, 0, ST_OK,     0, '0, '0);
    add_row(OP_INSERT, 0,  '1, '1, 1, 1, ST_FULL,   16, '0, '0);
    add_row(OP_INSERT, 16, '1, '1, 1, 1, ST_FULL,   16, '0, '0);
    add_row(OP_READ,   15, '0, '0, 1, 0, ST_OK,      0, '0, '0);
    add_row(OP_REMOVE, 15, '0, '0, 1, 1, ST_OK,     15, '0, '0);
    add_row(OP_REMOVE, 0,  '0, '0, 1, 1, ST_OK,     14, '0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cmd_table[i]) begin
      row = cmd_table[i];
      if (row.reps > 1) begin
        repeat (row.reps) begin
          offer_word(row.op, list_len[4:0], $urandom, $urandom, 1'b0, none, 1'b0);
        end
      end else begin
        offer_word(row.op, row.pos, row.x_wr, row.y_wr, row.typed, row.res, 1'b0);
      end
    end

    // Random traffic swings the list between empty and full so that every
    // shift depth and both boundaries are exercised.
    filling = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 500 && n < 700);
      if (list_len >= CAPACITY) begin
        filling = 1'b0;
      end else if (list_len == 0 || $urandom_range(0, 99) < 2) begin
        filling = (list_len == 0) ? 1'b1 : ~filling;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = OP_UNUSED;
      end else if (r < 20) begin
        op = OP_READ;
      end else if (r < 75) begin
        op = filling ? OP_INSERT : OP_REMOVE;
      end else begin
        op = filling ? OP_REMOVE : OP_INSERT;
      end
      if ($urandom_range(0, 99) < 85) begin
        if (op == OP_INSERT) begin
          pos = 5'($urandom_range(0, list_len));
        end else begin
          pos = 5'($urandom_range(0, list_len == 0 ? 0 : list_len - 1));
        end
      end else begin
        pos = 5'($urandom_range(0, 31));
      end
      r = $urandom_range(0, 9);
      xw = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
      yw = (r == 2) ? '0 : (r == 3) ? '1 : $urandom;
      offer_word(op, pos, xw, yw, 1'b0, none, n == 1000);
    end
    steady = 1'b0;
    s_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
